[rtl/core/gffp_pkg.sv]
// Shared types, field widths and codes of the grid first-fit placer.
package gffp_pkg;

    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 4096;
    localparam int MAX_SPAN_DEF  = 8;

    localparam int OP_W   = 2;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 12;
    localparam int SPAN_W = 4;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] COLS_RESET = 7'd6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_OCCUPY = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_OCC_RD,
        ST_OCC_WR,
        ST_FIND,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [COL_W-1:0]  pos_col;
        logic [ROW_W-1:0]  pos_row;
        logic [SPAN_W-1:0] span_width;
        logic [SPAN_W-1:0] span_height;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [COL_W-1:0]  slot_col;
        logic [ROW_W-1:0]  slot_row;
    } out_item_t;

endpackage

[rtl/core/gffp_row_mem.sv]
// Occupancy row memory with one write port and one registered read port.
module gffp_row_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

[rtl/core/gffp_fit_search.sv]
// Leftmost free run search over one combined busy word.
module gffp_fit_search #(
    parameter int GRID_COLS = 64,
    parameter int MAX_SPAN  = 8
) (
    input  logic [GRID_COLS-1:0]          busy,
    input  logic [$clog2(MAX_SPAN+1)-1:0] span,
    input  logic [gffp_pkg::CFG_W-1:0]    cols,
    output logic                          hit,
    output logic [gffp_pkg::COL_W-1:0]    col
);
    import gffp_pkg::*;

    logic [GRID_COLS+MAX_SPAN-1:0] busy_ext;
    logic [GRID_COLS-1:0]          fit;

    assign busy_ext = {{MAX_SPAN{1'b1}}, busy};

    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            fit[c] = ((c + int'(span)) <= int'(cols));
            for (int j = 0; j < MAX_SPAN; j++) begin
                if (j < int'(span) && busy_ext[c+j]) begin
                    fit[c] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        col = '0;
        for (int c = GRID_COLS - 1; c >= 0; c--) begin
            if (fit[c]) begin
                hit = 1'b1;
                col = COL_W'(c);
            end
        end
    end

endmodule

[rtl/core/gffp_seq.sv]
// Sequencer for clear sweeps, occupy read-modify-write and the streaming find scan.
module gffp_seq #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 4096,
    parameter int MAX_SPAN  = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  gffp_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output gffp_pkg::out_item_t              m_item,
    input  logic [gffp_pkg::CFG_W-1:0]       cols,
    output logic                             mem_wr_en,
    output logic [$clog2(GRID_ROWS)-1:0]     mem_wr_addr,
    output logic [GRID_COLS-1:0]             mem_wr_data,
    output logic                             mem_rd_en,
    output logic [$clog2(GRID_ROWS)-1:0]     mem_rd_addr,
    input  logic [GRID_COLS-1:0]             mem_rd_data,
    output logic [GRID_COLS-1:0]             busy_word,
    output logic [$clog2(MAX_SPAN+1)-1:0]    span,
    input  logic                             fit_hit,
    input  logic [gffp_pkg::COL_W-1:0]       fit_col
);
    import gffp_pkg::*;

    localparam int RAW = $clog2(GRID_ROWS);
    localparam int SPW = $clog2(MAX_SPAN + 1);
    localparam int IW  = $clog2(GRID_ROWS + MAX_SPAN);

    state_t state_reg, state_next;

    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [SPW-1:0]       w_reg;
    logic [SPW-1:0]       h_reg;
    logic [SPW-1:0]       k_reg;
    logic [RAW-1:0]       sweep_reg;
    logic [IW-1:0]        iss_reg;
    logic [IW-1:0]        idx_reg;
    logic                 rdv_reg;
    logic                 rdz_reg;
    logic                 wv_reg;
    logic [RAW-1:0]       wrow_reg;
    logic [GRID_COLS-1:0] win_reg [MAX_SPAN];
    logic [GRID_COLS-1:0] busy_reg;
    logic                 bv_reg;
    logic [RAW-1:0]       brow_reg;
    logic                 res_found_reg;
    logic [COL_W-1:0]     res_col_reg;
    logic [ROW_W-1:0]     res_row_reg;
    out_item_t            m_item_reg;
    logic                 m_valid_reg;

    logic                 accept;
    logic                 sweep_last;
    logic [ROW_W:0]       occ_row;
    logic                 occ_in_grid;
    logic [GRID_COLS-1:0] occ_mask;
    logic                 issue_go;
    logic                 issue_real;
    logic [GRID_COLS-1:0] busy_comb;
    logic                 find_done;
    logic                 load_out;

    function automatic logic [SPW-1:0] clamp_span(input logic [SPAN_W-1:0] v);
        logic [SPW-1:0] r;
        if (v == '0) begin
            r = SPW'(1);
        end else if (int'(v) > MAX_SPAN) begin
            r = SPW'(MAX_SPAN);
        end else begin
            r = SPW'(v);
        end
        return r;
    endfunction

    assign accept      = s_valid && s_ready;
    assign sweep_last  = (int'(sweep_reg) == GRID_ROWS - 1);
    assign occ_row     = {1'b0, row_reg} + (ROW_W+1)'(k_reg);
    assign occ_in_grid = (int'(occ_row) < GRID_ROWS);
    assign issue_real  = (int'(iss_reg) < GRID_ROWS);
    assign issue_go    = (state_reg == ST_FIND)
                         && (int'(iss_reg) < GRID_ROWS + int'(h_reg) - 1);
    assign find_done   = bv_reg && (fit_hit || int'(brow_reg) == GRID_ROWS - 1);
    assign load_out    = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    assign span      = (int'(w_reg) < int'(cols)) ? w_reg : SPW'(cols);
    assign busy_word = busy_reg;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            occ_mask[c] = (c >= int'(col_reg)) && (c < int'(col_reg) + int'(w_reg));
        end
    end

    always_comb begin
        busy_comb = '0;
        for (int k = 0; k < MAX_SPAN; k++) begin
            if (k < int'(h_reg)) begin
                busy_comb = busy_comb | win_reg[k];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_item.operation)
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_OCCUPY: state_next = ST_OCC_RD;
                        OP_FIND:   state_next = ST_FIND;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (sweep_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_OCC_RD: begin
                state_next = occ_in_grid ? ST_OCC_WR : ST_RESP;
            end
            ST_OCC_WR: begin
                if (k_reg == h_reg - SPW'(1)) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_OCC_RD;
                end
            end
            ST_FIND: begin
                if (find_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = occ_row[RAW-1:0];
        mem_wr_data = mem_rd_data | occ_mask;
        mem_rd_en   = 1'b0;
        mem_rd_addr = iss_reg[RAW-1:0];
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_reg;
                mem_wr_data = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_OCC_RD: begin
                mem_rd_en   = occ_in_grid;
                mem_rd_addr = occ_row[RAW-1:0];
            end
            ST_OCC_WR: begin
                mem_wr_en = 1'b1;
            end
            ST_FIND: begin
                mem_rd_en = issue_go && issue_real;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
            sweep_reg <= sweep_last ? '0 : sweep_reg + RAW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg       <= s_item.pos_col;
            row_reg       <= s_item.pos_row;
            w_reg         <= clamp_span(s_item.span_width);
            h_reg         <= clamp_span(s_item.span_height);
            k_reg         <= '0;
            res_found_reg <= 1'b0;
            res_col_reg   <= '0;
            res_row_reg   <= '0;
        end else begin
            if (state_reg == ST_OCC_WR) begin
                k_reg <= k_reg + SPW'(1);
            end
            if (state_reg == ST_FIND && bv_reg && fit_hit) begin
                res_found_reg <= 1'b1;
                res_col_reg   <= fit_col;
                res_row_reg   <= ROW_W'(brow_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg <= '0;
            idx_reg <= '0;
            rdv_reg <= 1'b0;
            wv_reg  <= 1'b0;
            bv_reg  <= 1'b0;
        end else if (state_reg == ST_FIND) begin
            if (issue_go) begin
                iss_reg <= iss_reg + IW'(1);
            end
            rdv_reg <= issue_go;
            if (rdv_reg) begin
                idx_reg <= idx_reg + IW'(1);
                wv_reg  <= (int'(idx_reg) >= int'(h_reg) - 1);
            end else begin
                wv_reg <= 1'b0;
            end
            bv_reg <= wv_reg;
        end else begin
            iss_reg <= '0;
            idx_reg <= '0;
            rdv_reg <= 1'b0;
            wv_reg  <= 1'b0;
            bv_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rdz_reg <= !issue_real;
        if (rdv_reg) begin
            win_reg[0] <= rdz_reg ? '0 : mem_rd_data;
            for (int k = 1; k < MAX_SPAN; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
            wrow_reg <= RAW'(idx_reg - IW'(h_reg) + IW'(1));
        end
        busy_reg <= busy_comb;
        brow_reg <= wrow_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_item_reg.found    <= res_found_reg;
            m_item_reg.slot_col <= res_col_reg;
            m_item_reg.slot_row <= res_row_reg;
        end
    end

endmodule

[rtl/core/grid_first_fit_placer_top.sv]
// Top level of the grid first-fit placer: column register, row memory, sequencer, fit search.
//
//   channel   ports                        direction  contents
//   s_        s_valid s_ready s_item       in         operation, position, spans
//   m_        m_valid m_ready m_item       out        found, slot column, slot row
//   cfg_      cfg_wr_en cfg_wr_data        in         columns in use
//
// One item is processed at a time. A clear sweeps every row, an occupy reads and writes
// each covered row of the grid in turn, and a find makes one row-memory read per row
// while the rows pass through a window of the last height rows.
// After reset a sweep empties every row of the memory, and s_ready stays low meanwhile.
// A result waits in the output register; a new transfer is taken once it is loaded.
module grid_first_fit_placer_top #(
    parameter int GRID_COLS = gffp_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = gffp_pkg::GRID_ROWS_DEF,
    parameter int MAX_SPAN  = gffp_pkg::MAX_SPAN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  gffp_pkg::in_item_t         s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output gffp_pkg::out_item_t        m_item,
    input  logic                       cfg_wr_en,
    input  logic [gffp_pkg::CFG_W-1:0] cfg_wr_data
);
    import gffp_pkg::*;

    localparam int RAW = $clog2(GRID_ROWS);
    localparam int SPW = $clog2(MAX_SPAN + 1);

    logic [CFG_W-1:0]     cols_reg;
    logic [CFG_W-1:0]     cols_sat;
    logic                 mem_wr_en;
    logic [RAW-1:0]       mem_wr_addr;
    logic [GRID_COLS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [RAW-1:0]       mem_rd_addr;
    logic [GRID_COLS-1:0] mem_rd_data;
    logic [GRID_COLS-1:0] busy_word;
    logic [SPW-1:0]       span;
    logic                 fit_hit;
    logic [COL_W-1:0]     fit_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
        end else if (cfg_wr_en) begin
            cols_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (cols_reg == '0) begin
            cols_sat = CFG_W'(1);
        end else if (int'(cols_reg) > GRID_COLS) begin
            cols_sat = CFG_W'(GRID_COLS);
        end else begin
            cols_sat = cols_reg;
        end
    end

    gffp_row_mem #(
        .DEPTH (GRID_ROWS),
        .WIDTH (GRID_COLS)
    ) u_row_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    gffp_fit_search #(
        .GRID_COLS (GRID_COLS),
        .MAX_SPAN  (MAX_SPAN)
    ) u_fit_search (
        .busy (busy_word),
        .span (span),
        .cols (cols_sat),
        .hit  (fit_hit),
        .col  (fit_col)
    );

    gffp_seq #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .MAX_SPAN  (MAX_SPAN)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cols        (cols_sat),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .busy_word   (busy_word),
        .span        (span),
        .fit_hit     (fit_hit),
        .fit_col     (fit_col)
    );

endmodule

[tb/sv/grid_first_fit_placer_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the grid first-fit placer: directed cases, back-pressure, random traffic.
module grid_first_fit_placer_top_tb;
    import gffp_pkg::*;

    localparam int GRID_COLS   = GRID_COLS_DEF;
    localparam int GRID_ROWS   = GRID_ROWS_DEF;
    localparam int MAX_SPAN    = MAX_SPAN_DEF;
    localparam int CLK_PERIOD  = 12;
    localparam int HOLD_CYCLES = 3 * GRID_ROWS;
    localparam int TAIL_CYCLES = 64;
    localparam longint CYCLE_LIMIT =
        64'd4 * 800 * (GRID_ROWS + 4 * MAX_SPAN + 64) + 4 * GRID_ROWS + 4 * HOLD_CYCLES;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_item_t         s_item      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_item_t        m_item;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    logic [63:0]      occ_rows [GRID_ROWS];
    logic [CFG_W-1:0] cols_reg = COLS_RESET;
    out_item_t        predicted_slots [$];
    int               mismatches = 0;
    longint           cycle_count = 0;
    bit               idle_on = 1'b1;
    int unsigned      hold_req = 0;
    int unsigned      hold_seen = 0;
    int unsigned      rx_wait = 0;

    grid_first_fit_placer_top #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .MAX_SPAN  (MAX_SPAN)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int clamp_span(logic [SPAN_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SPAN) return MAX_SPAN;
        return int'(v);
    endfunction

    function automatic int active_columns(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > GRID_COLS) return GRID_COLS;
        return int'(v);
    endfunction

    function automatic out_item_t predict_slot(in_item_t item);
        out_item_t   res;
        int          w, h, cols, span, r, k, c, col0, row0;
        logic [63:0] busy, mask;
        bit          done;
        res  = '0;
        done = 1'b0;
        w    = clamp_span(item.span_width);
        h    = clamp_span(item.span_height);
        col0 = int'(item.pos_col);
        row0 = int'(item.pos_row);
        case (item.operation)
            OP_CLEAR: begin
                for (r = 0; r < GRID_ROWS; r++) occ_rows[r] = '0;
            end
            OP_OCCUPY: begin
                mask = '0;
                for (c = col0; c < col0 + w; c++)
                    if (c < GRID_COLS) mask[c] = 1'b1;
                for (r = row0; r < row0 + h; r++)
                    if (r < GRID_ROWS) occ_rows[r] = occ_rows[r] | mask;
            end
            OP_FIND: begin
                cols = active_columns(cols_reg);
                span = (w < cols) ? w : cols;
                for (r = 0; r < GRID_ROWS && !done; r++) begin
                    busy = '0;
                    for (k = 0; k < h; k++)
                        if (r + k < GRID_ROWS) busy = busy | occ_rows[r + k];
                    for (c = 0; c + span <= cols && !done; c++) begin
                        mask = ((64'd1 << span) - 64'd1) << c;
                        if ((busy & mask) == '0) begin
                            res.found    = 1'b1;
                            res.slot_col = COL_W'(c);
                            res.slot_row = ROW_W'(r);
                            done         = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic in_item_t pack_item(logic [OP_W-1:0] op, logic [COL_W-1:0] col,
                                           logic [ROW_W-1:0] row, logic [SPAN_W-1:0] w,
                                           logic [SPAN_W-1:0] h);
        in_item_t item;
        item.operation   = op;
        item.pos_col     = col;
        item.pos_row     = row;
        item.span_width  = w;
        item.span_height = h;
        return item;
    endfunction

    function automatic in_item_t random_item(int col_hi);
        int                pick;
        logic [OP_W-1:0]   op;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SPAN_W-1:0] w, h;
        pick = $urandom_range(0, 99);
        if (pick < 6) op = OP_CLEAR;
        else if (pick < 10) op = OP_UNUSED;
        else if (pick < 55) op = OP_OCCUPY;
        else op = OP_FIND;
        if ($urandom_range(0, 9) < 7) col = COL_W'($urandom_range(0, col_hi));
        else col = COL_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 19);
        if (pick < 15) row = ROW_W'($urandom_range(0, 40));
        else if (pick < 18) row = ROW_W'($urandom_range(GRID_ROWS - 16, GRID_ROWS - 1));
        else row = ROW_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 4) == 0) w = SPAN_W'($urandom_range(0, 15));
        else w = SPAN_W'($urandom_range(1, MAX_SPAN));
        if ($urandom_range(0, 4) == 0) h = SPAN_W'($urandom_range(0, 15));
        else h = SPAN_W'($urandom_range(1, MAX_SPAN));
        return pack_item(op, col, row, w, h);
    endfunction

    function automatic void check_field(string field, logic [ROW_W-1:0] want,
                                        logic [ROW_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Each call starts and ends at a falling edge; valid is left high until the next call or a drain.
    task automatic offer_item(in_item_t item);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted_slots.push_back(predict_slot(item));
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (predicted_slots.size() != 0) @(negedge aclk);
    endtask

    task automatic set_columns(logic [CFG_W-1:0] value);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cols_reg     = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_after_reset();
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd8));
        offer_item(pack_item(OP_OCCUPY, 6'd0, 12'd0, 4'd6, 4'd1));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd1, 4'd1));
        offer_item(pack_item(OP_UNUSED, 6'd63, 12'd4095, 4'd15, 4'd15));
        offer_item(pack_item(OP_FIND, 6'd63, 12'd4095, 4'd2, 4'd3));
    endtask

    task automatic test_span_saturation();
        offer_item(pack_item(OP_OCCUPY, 6'd2, 12'd1, 4'd0, 4'd15));
        offer_item(pack_item(OP_OCCUPY, 6'd3, 12'd0, 4'd15, 4'd0));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd0, 4'd0));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd15, 4'd15));
    endtask

    task automatic test_grid_edge();
        set_columns(7'd127);
        offer_item(pack_item(OP_OCCUPY, 6'd63, 12'd4095, 4'd8, 4'd8));
        offer_item(pack_item(OP_OCCUPY, 6'd60, 12'd4090, 4'd15, 4'd15));
        offer_item(pack_item(OP_OCCUPY, 6'd0, 12'd0, 4'd8, 4'd8));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd8));
    endtask

    task automatic test_clear();
        offer_item(pack_item(OP_CLEAR, 6'd63, 12'd4095, 4'd15, 4'd15));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd8));
    endtask

    task automatic test_column_count();
        offer_item(pack_item(OP_OCCUPY, 6'd0, 12'd0, 4'd8, 4'd1));
        set_columns(7'd0);
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd1));
        set_columns(7'd1);
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd1));
        set_columns(7'd64);
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd1));
        set_columns(7'd65);
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd1));
        set_columns(7'd9);
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd8, 4'd1));
    endtask

    task automatic test_backpressure();
        set_columns(7'd6);
        hold_req <= hold_req + 1;
        offer_item(pack_item(OP_OCCUPY, 6'd1, 12'd2, 4'd3, 4'd2));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd4, 4'd3));
        offer_item(pack_item(OP_OCCUPY, 6'd0, 12'd0, 4'd2, 4'd1));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd6, 4'd1));
        offer_item(pack_item(OP_UNUSED, 6'd5, 12'd7, 4'd1, 4'd1));
        offer_item(pack_item(OP_FIND, 6'd0, 12'd0, 4'd1, 4'd2));
        wait_drain();
    endtask

    task automatic test_random_traffic(int count, logic [CFG_W-1:0] cols);
        int col_hi;
        set_columns(cols);
        col_hi = active_columns(cols) + 2;
        if (col_hi > 63) col_hi = 63;
        repeat (count) offer_item(random_item(col_hi));
        wait_drain();
    endtask

    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            rx_wait   <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_wait <= $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : compare_slots
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_slots.size() == 0) begin
                $display("%0t: result with no transfer pending, found %0d col %0d row %0d",
                         $time, m_item.found, m_item.slot_col, m_item.slot_row);
                mismatches++;
            end else begin
                want = predicted_slots.pop_front();
                check_field("found", ROW_W'(want.found), ROW_W'(m_item.found));
                check_field("slot_col", ROW_W'(want.slot_col), ROW_W'(m_item.slot_col));
                check_field("slot_row", want.slot_row, m_item.slot_row);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("grid_first_fit_placer_top test failed");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < GRID_ROWS; r++) occ_rows[r] = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_span_saturation();
        test_grid_edge();
        test_clear();
        test_column_count();
        test_backpressure();
        test_random_traffic(28, 7'd6);
        test_random_traffic(28, 7'd64);
        test_random_traffic(28, CFG_W'($urandom_range(2, 63)));
        idle_on <= 1'b0;
        test_random_traffic(28, CFG_W'($urandom_range(0, 127)));
        wait_drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && predicted_slots.size() == 0) begin
            $display("grid_first_fit_placer_top test passed");
        end else begin
            $display("grid_first_fit_placer_top test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/gffp_pkg.sv
rtl/core/gffp_row_mem.sv
rtl/core/gffp_fit_search.sv
rtl/core/gffp_seq.sv
rtl/core/grid_first_fit_placer_top.sv
tb/sv/grid_first_fit_placer_top_tb.sv
